/* src/rdr565_pkg.sv */
// rdr565_pkg: types, constants and the delta expansion for the rle/delta rgb565 decoder
// no dependencies; used by every module of the decoder
package rdr565_pkg;

   typedef enum logic [1:0] {
      PH_START   = 2'd0,
      PH_WORD_HI = 2'd1,
      PH_CNT_HI  = 2'd2,
      PH_CNT_LO  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [15:0] pixel;
      logic [15:0] repeat_res;
   } result_type;

   localparam logic [7:0]  WORD_FLAG = 8'h20;
   localparam logic [15:0] RED_MASK  = 16'h1800;
   localparam logic [15:0] GRN_MASK  = 16'h00e3;
   localparam logic [15:0] LOW_MASK  = 16'h0003;
   localparam logic [15:0] ONE_PIXEL = 16'd1;

   function automatic logic [15:0] delta_bits(input logic [7:0] b);
      logic [15:0] w;
      w = {8'h00, b};
      return ((w << 5) & RED_MASK) | ((w << 3) & GRN_MASK) | (w & LOW_MASK);
   endfunction

endpackage

/* src/rdr565_parse.sv */
// rdr565_parse: token parser state and single-pass decode of one code byte
// depends on rdr565_pkg
module rdr565_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [7:0]               code_byte,
   input  logic                     image_start,
   output logic                     res_valid,
   output rdr565_pkg::result_type   res
);

   rdr565_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [7:0]  held_low_byte_ff, held_low_byte_in, held_low_byte_cur;
   logic [7:0]  held_count_high_ff, held_count_high_in, held_count_high_cur;
   logic [15:0] last_literal_ff, last_literal_in, last_literal_cur;
   logic [15:0] last_pixel_ff, last_pixel_in, last_pixel_cur;
   logic [15:0] word;
   logic [15:0] count;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= rdr565_pkg::PH_START;
         held_low_byte_ff   <= 8'h00;
         held_count_high_ff <= 8'h00;
         last_literal_ff    <= 16'h0000;
         last_pixel_ff      <= 16'h0000;
      end else if (advance) begin
         phase_ff           <= phase_in;
         held_low_byte_ff   <= held_low_byte_in;
         held_count_high_ff <= held_count_high_in;
         last_literal_ff    <= last_literal_in;
         last_pixel_ff      <= last_pixel_in;
      end
   end

   always_comb begin
      // new image clears everything before the byte is parsed
      if (image_start) begin
         phase_cur           = rdr565_pkg::PH_START;
         held_low_byte_cur   = 8'h00;
         held_count_high_cur = 8'h00;
         last_literal_cur    = 16'h0000;
         last_pixel_cur      = 16'h0000;
      end else begin
         phase_cur           = phase_ff;
         held_low_byte_cur   = held_low_byte_ff;
         held_count_high_cur = held_count_high_ff;
         last_literal_cur    = last_literal_ff;
         last_pixel_cur      = last_pixel_ff;
      end

      word  = {code_byte, held_low_byte_cur};
      count = {held_count_high_cur, code_byte};

      phase_in           = phase_cur;
      held_low_byte_in   = held_low_byte_cur;
      held_count_high_in = held_count_high_cur;
      last_literal_in    = last_literal_cur;
      last_pixel_in      = last_pixel_cur;
      res_valid          = 1'b0;
      res.pixel          = last_pixel_cur;
      res.repeat_res     = rdr565_pkg::ONE_PIXEL;

      unique case (phase_cur)
         rdr565_pkg::PH_START: begin
            if ((code_byte & rdr565_pkg::WORD_FLAG) != 8'h00) begin
               held_low_byte_in = code_byte;
               phase_in         = rdr565_pkg::PH_WORD_HI;
            end else begin
               last_pixel_in = last_literal_cur ^ rdr565_pkg::delta_bits(code_byte);
               res.pixel     = last_pixel_in;
               res_valid     = 1'b1;
            end
         end
         rdr565_pkg::PH_WORD_HI: begin
            if (word == last_literal_cur) begin
               phase_in = rdr565_pkg::PH_CNT_HI;
            end else begin
               last_literal_in = word;
               last_pixel_in   = word;
               phase_in        = rdr565_pkg::PH_START;
               res.pixel       = word;
               res_valid       = 1'b1;
            end
         end
         rdr565_pkg::PH_CNT_HI: begin
            held_count_high_in = code_byte;
            phase_in           = rdr565_pkg::PH_CNT_LO;
         end
         rdr565_pkg::PH_CNT_LO: begin
            phase_in       = rdr565_pkg::PH_START;
            res.repeat_res = count;
            res_valid      = (count != 16'h0000);
         end
         default: begin
            phase_in = rdr565_pkg::PH_START;
         end
      endcase
   end

endmodule

/* src/rdr565_out_reg.sv */
// rdr565_out_reg: result register between the parser and the rsp channel
// depends on rdr565_pkg
module rdr565_out_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic                     load_valid,
   input  rdr565_pkg::result_type   load_data,
   output logic                     space,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rdr565_pkg::result_type   out_data
);

   logic                   valid_ff, valid_in;
   rdr565_pkg::result_type data_ff;

   // free when empty or being taken this cycle
   assign space = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = load_valid;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* src/rle_delta_rgb565_decoder_top.sv */
// rle_delta_rgb565_decoder_top: byte-serial rle/delta rgb565 image decoder
// depends on rdr565_pkg, rdr565_parse and rdr565_out_reg
//
//   channel | ports                                  | moves
//   req     | req_valid req_ready req_code_byte      | one code byte per request
//           | req_image_start                        |
//   rsp     | rsp_valid rsp_ready rsp_pixel          | one pixel with its repeat count
//           | rsp_repeat_res                         |
//
// one request accepted per cycle while req_ready is high; its result, if any, is shown the next cycle
// from the result register, set by the single-pass parse of the byte
// reset clears the parser state and empties the result register
// req_ready drops only while a result is held and rsp_ready is low
module rle_delta_rgb565_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_code_byte,
   input  logic        req_image_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_pixel,
   output logic [15:0] rsp_repeat_res
);

   logic                   accept;
   logic                   res_valid;
   logic                   space;
   rdr565_pkg::result_type res;
   rdr565_pkg::result_type rsp_data;

   assign req_ready = space;
   assign accept    = req_valid && space;

   rdr565_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .code_byte   (req_code_byte),
      .image_start (req_image_start),
      .res_valid   (res_valid),
      .res         (res)
   );

   rdr565_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_valid (res_valid),
      .load_data  (res),
      .space      (space),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (rsp_data)
   );

   assign rsp_pixel      = rsp_data.pixel;
   assign rsp_repeat_res = rsp_data.repeat_res;

endmodule
